// ----- hdl/lltc_pkg.sv -----
// Package for the LCD line timing controller: codes, widths and shared types.
`default_nettype none
package lltc_pkg;

  localparam int unsigned LINE_W      = 8;
  localparam int unsigned CYCLE_W     = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned OAM_CYCLES  = 80;
  localparam int unsigned XFER_CYCLES = 172;

  typedef enum logic {
    OP_ADVANCE    = 1'b0,
    OP_LINE_RESET = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPLAY_ENABLE   = 3'd0,
    CFG_LINE_COMPARE     = 3'd1,
    CFG_COMPARE_IRQ_EN   = 3'd2,
    CFG_OAM_IRQ_EN       = 3'd3,
    CFG_VBLANK_IRQ_EN    = 3'd4,
    CFG_HBLANK_IRQ_EN    = 3'd5
  } cfg_idx_e;

  // Configuration state handed from the register file to the timing core.
  typedef struct packed {
    logic              display_enable;
    logic [LINE_W-1:0] line_compare;
    logic              compare_irq_enable;
    logic              oam_irq_enable;
    logic              vblank_irq_enable;
    logic              hblank_irq_enable;
  } cfg_t;

  // One result item as held in the output register.
  typedef struct packed {
    logic [LINE_W-1:0] current_line;
    mode_e             current_mode;
    logic              coincidence;
    logic              render_strobe;
    logic [LINE_W-1:0] render_row;
    logic              vblank_pulse;
    logic              frame_done;
    logic              stat_irq;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/lltc_if.sv -----
// Channel interfaces of the LCD line timing controller: input, result and configuration.
`default_nettype none
interface lltc_in_if
  import lltc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               op;
  logic [CYCLE_W-1:0] cycle_count;

  modport source (output valid, output op, output cycle_count, input ready);
  modport sink   (input valid, input op, input cycle_count, output ready);
endinterface

interface lltc_out_if
  import lltc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] current_line;
  logic [1:0]        current_mode;
  logic              coincidence;
  logic              render_strobe;
  logic [LINE_W-1:0] render_row;
  logic              vblank_pulse;
  logic              frame_done;
  logic              stat_irq;

  modport source (output valid, output current_line, output current_mode,
                  output coincidence, output render_strobe, output render_row,
                  output vblank_pulse, output frame_done, output stat_irq,
                  input ready);
  modport sink   (input valid, input current_line, input current_mode,
                  input coincidence, input render_strobe, input render_row,
                  input vblank_pulse, input frame_done, input stat_irq,
                  output ready);
endinterface

interface lltc_cfg_if
  import lltc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/lcd_line_timing_controller.sv -----
// Top level of the LCD line timing controller.
//
// Usage: the input channel in_i carries one transaction per CPU event. With
// op advance and the display on, the cycle_count value is taken off the line
// timer; with op line reset, only the line counter is cleared. Every input transaction
// yields exactly one result transaction on out_o with the line, mode,
// coincidence flag, render and vblank strobes, frame end and STAT request.
// Configuration registers are written through cfg_i (index, data), which is
// always ready; writes are meant to happen while no transaction is in flight.
// After acceptance, the input register holds the transaction until the state
// update, which also loads the result register. Throughput is one transaction
// per cycle while the receiver does not stall; it is set by the timer and line
// update that sits between the input and result registers.
// When the receiver stalls, the result register holds its transaction and
// one more input is buffered in the input register; in_i.ready then drops.
// Reset (rst_ni low, asynchronous) sets a full line timer, line 0, mode 2,
// a clear coincidence flag, display enabled and all interrupt enables off.
`default_nettype none
module lcd_line_timing_controller
  import lltc_pkg::*;
#(
  parameter int unsigned LINE_CYCLES   = 456,
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned TOTAL_LINES   = 154
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  lltc_cfg_if.sink   cfg_i,
  lltc_in_if.sink    in_i,
  lltc_out_if.source out_o
);

  // Register values shared with the timing core.
  cfg_t cfg;

  lltc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // The core owns the timing state; results are registered before out_o.
  lltc_core #(
    .LINE_CYCLES   (LINE_CYCLES),
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

// ----- hdl/lltc_cfg_regs.sv -----
// Configuration register file of the LCD line timing controller.
`default_nettype none
module lltc_cfg_regs
  import lltc_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  lltc_cfg_if.sink  cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_DISPLAY_ENABLE: cfg_d.display_enable     = cfg_i.data[0];
        CFG_LINE_COMPARE:   cfg_d.line_compare       = cfg_i.data[LINE_W-1:0];
        CFG_COMPARE_IRQ_EN: cfg_d.compare_irq_enable = cfg_i.data[0];
        CFG_OAM_IRQ_EN:     cfg_d.oam_irq_enable     = cfg_i.data[0];
        CFG_VBLANK_IRQ_EN:  cfg_d.vblank_irq_enable  = cfg_i.data[0];
        CFG_HBLANK_IRQ_EN:  cfg_d.hblank_irq_enable  = cfg_i.data[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q                    <= '0;
      cfg_q.display_enable     <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- hdl/lltc_core.sv -----
// Timing core: input register, line/mode state update and result register.
`default_nettype none
module lltc_core
  import lltc_pkg::*;
#(
  parameter int unsigned LINE_CYCLES   = 456,
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned TOTAL_LINES   = 154
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire cfg_t  cfg_i,
  lltc_in_if.sink    in_i,
  lltc_out_if.source out_o
);

  localparam int unsigned TIMER_W = $clog2(LINE_CYCLES + 1);
  localparam logic [TIMER_W-1:0] TimerFull  = TIMER_W'(LINE_CYCLES);
  localparam logic [TIMER_W-1:0] OamStart   = TIMER_W'(LINE_CYCLES - OAM_CYCLES);
  localparam logic [TIMER_W-1:0] XferStart  =
    TIMER_W'(LINE_CYCLES - OAM_CYCLES - XFER_CYCLES);
  localparam logic [LINE_W-1:0]  VisLines   = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0]  TotLines   = LINE_W'(TOTAL_LINES);

  // Input stage.
  logic               s1_valid_q;
  op_e                s1_op_q;
  logic [CYCLE_W-1:0] s1_cycles_q;

  // Timing state.
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic [LINE_W-1:0]  line_q, line_d;
  mode_e              mode_q, mode_d;
  logic               coin_q, coin_d;

  // Result stage.
  logic out_valid_q;
  res_t res_q, res_d;

  logic s1_adv;
  logic in_fire;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_fire     = in_i.valid && in_i.ready;

  always_comb begin
    logic              want;
    logic [LINE_W-1:0] line_inc;
    want     = 1'b0;
    line_inc = line_q + LINE_W'(1);
    timer_d  = timer_q;
    line_d   = line_q;
    mode_d   = mode_q;
    coin_d   = coin_q;
    res_d    = '0;

    if (s1_op_q == OP_LINE_RESET) begin
      line_d = '0;
    end else if (!cfg_i.display_enable) begin
      timer_d = TimerFull;
      line_d  = '0;
      mode_d  = MODE_VBLANK;
    end else begin
      if (TIMER_W'(s1_cycles_q) >= timer_q) begin
        timer_d = TimerFull;
        line_d  = line_inc;
        if (line_q >= VisLines) begin
          res_d.vblank_pulse = 1'b1;
          if (line_inc >= TotLines) begin
            line_d           = '0;
            res_d.frame_done = 1'b1;
          end
        end else begin
          res_d.render_strobe = 1'b1;
          res_d.render_row    = line_q;
        end
      end else begin
        timer_d = timer_q - TIMER_W'(s1_cycles_q);
      end

      if (line_d >= VisLines) begin
        mode_d = MODE_VBLANK;
        want   = cfg_i.vblank_irq_enable;
      end else if (timer_d >= OamStart) begin
        mode_d = MODE_OAM;
        want   = cfg_i.oam_irq_enable;
      end else if (timer_d >= XferStart) begin
        mode_d = MODE_XFER;
      end else begin
        mode_d = MODE_HBLANK;
        want   = cfg_i.hblank_irq_enable;
      end

      coin_d         = (line_d == cfg_i.line_compare);
      res_d.stat_irq = (want && (mode_d != mode_q)) ||
                       (coin_d && cfg_i.compare_irq_enable);
    end

    res_d.current_line = line_d;
    res_d.current_mode = mode_d;
    res_d.coincidence  = coin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timer_q     <= TimerFull;
      line_q      <= '0;
      mode_q      <= MODE_OAM;
      coin_q      <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        timer_q     <= timer_d;
        line_q      <= line_d;
        mode_q      <= mode_d;
        coin_q      <= coin_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= op_e'(in_i.op);
      s1_cycles_q <= in_i.cycle_count;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.current_line  = res_q.current_line;
  assign out_o.current_mode  = res_q.current_mode;
  assign out_o.coincidence   = res_q.coincidence;
  assign out_o.render_strobe = res_q.render_strobe;
  assign out_o.render_row    = res_q.render_row;
  assign out_o.vblank_pulse  = res_q.vblank_pulse;
  assign out_o.frame_done    = res_q.frame_done;
  assign out_o.stat_irq      = res_q.stat_irq;

  // The line timer never runs down to zero and never exceeds a full line.
  a_timer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timer_q != '0) && (timer_q <= TimerFull))
    else $error("line timer out of range");

  // A frame end always leaves the line counter at zero.
  a_frame_line0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.frame_done) |-> (res_q.current_line == '0))
    else $error("frame end without line wrap");

  // A held input item is not dropped while the result stage is stalled.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_cycles_q)))
    else $error("input stage lost a stalled transaction");

  // A state update always produces a result transaction.
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("state advanced without a result");

  // An advance with the display on whose new line lies beyond the visible area
  // leaves the vblank mode in the mode register.
  a_vblank_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_op_q == OP_ADVANCE && cfg_i.display_enable && line_d >= VisLines)
      |=> (mode_q == MODE_VBLANK))
    else $error("vblank line with wrong mode");

endmodule
`default_nettype wire
